[hw/rtl/sensor_slot_tick_scheduler_defines.svh]
// Assertion macros for the sensor slot tick scheduler.
// Included by ssts_ctrl, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef SENSOR_SLOT_TICK_SCHEDULER_DEFINES_SVH
`define SENSOR_SLOT_TICK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge, reset is ignored.
`define SSTS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// Checked outside of reset only.
`define SSTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define SSTS_ASSERT_NR(lbl, clk, prop, msg)
`define SSTS_ASSERT(lbl, clk, rst_n, prop, msg)
`endif
`endif

[hw/rtl/ssts_pkg.sv]
// Shared constants, register indexes and control structs of the tick scheduler.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package ssts_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BYTE_W    = 8;

  // serial divider: 32-bit dividend, up to 16-bit divisor, 2 quotient bits a cycle
  localparam int unsigned DIV_W     = TIME_W;
  localparam int unsigned DIVR_W    = 16;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_ITER  = DIV_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER);

  localparam logic [15:0]       WINDOW_PERIOD_RST    = 16'd60;
  localparam logic [15:0]       SENSING_INTERVAL_RST = 16'd60;
  localparam logic [BYTE_W-1:0] SLOT_LENGTH_RST      = 8'd2;
  localparam logic [BYTE_W-1:0] SENSOR_COUNT_RST     = 8'd16;
  localparam logic [BYTE_W-1:0] OWN_SLOT_RST         = 8'd0;
  localparam logic [BYTE_W-1:0] UNSYNCED_PERIOD_RST  = 8'd15;
  localparam logic [BYTE_W-1:0] SLEEP_LENGTH_RST     = 8'd55;
  localparam logic [BYTE_W-1:0] OWNER_NONE           = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_PERIOD    = 3'd0,
    CFG_SENSING_INTERVAL = 3'd1,
    CFG_SLOT_LENGTH      = 3'd2,
    CFG_SENSOR_COUNT     = 3'd3,
    CFG_OWN_SLOT         = 3'd4,
    CFG_UNSYNCED_PERIOD  = 3'd5,
    CFG_SLEEP_LENGTH     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic capture;  // latch tick inputs, advance counters
    logic start1;   // start remainder pass and slot timer divide
    logic start2;   // start owner modulo pass
    logic commit;   // update state, load result register
  } ssts_cmd_t;

  typedef struct packed {
    logic div_idle;
  } ssts_stat_t;

endpackage

`default_nettype wire

[hw/rtl/ssts_div.sv]
// Serial restoring divider, two quotient bits per cycle.
// Uses ssts_pkg for widths. A zero divisor gives all-ones quotient, remainder = dividend.
`default_nettype none

module ssts_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ssts_pkg::DIV_W-1:0]   dividend_i,
  input  logic [ssts_pkg::DIVR_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic [ssts_pkg::DIV_W-1:0]   quot_o,
  output logic [ssts_pkg::DIV_W-1:0]   rem_o
);

  logic                           busy_q;
  logic [ssts_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [ssts_pkg::DIVR_W-1:0]    r_q, r_d;
  logic [ssts_pkg::DIV_W-1:0]     dq_q, dq_d;
  logic [ssts_pkg::DIV_W-1:0]     dvd_q;
  logic [ssts_pkg::DIVR_W-1:0]    dvs_q;
  logic                           zero_q;

  always_comb begin
    logic [ssts_pkg::DIVR_W:0] t;
    logic [ssts_pkg::DIVR_W:0] diff;
    r_d  = r_q;
    dq_d = dq_q;
    for (int k = 0; k < ssts_pkg::DIV_STEPS; k++) begin
      t    = {r_d, dq_d[ssts_pkg::DIV_W-1]};
      diff = t - {1'b0, dvs_q};
      dq_d = {dq_d[ssts_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        r_d     = diff[ssts_pkg::DIVR_W-1:0];
        dq_d[0] = 1'b1;
      end else begin
        r_d = t[ssts_pkg::DIVR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ssts_pkg::DIV_CNT_W'(ssts_pkg::DIV_ITER - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= '0;
      dq_q   <= dividend_i;
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      r_q  <= r_d;
      dq_q <= dq_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = zero_q ? '1 : dq_q;
  assign rem_o  = zero_q ? dvd_q
                         : {{(ssts_pkg::DIV_W - ssts_pkg::DIVR_W){1'b0}}, r_q};

endmodule

`default_nettype wire

[hw/rtl/ssts_ctrl.sv]
// Sequencer of the tick scheduler: handshakes, divider passes, commit.
// Uses ssts_pkg and the assertion macros header.
`default_nettype none
`include "sensor_slot_tick_scheduler_defines.svh"

module ssts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ssts_pkg::ssts_cmd_t  cmd_o,
  input  ssts_pkg::ssts_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START1,
    S_WAIT1,
    S_START2,
    S_WAIT2,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.start1  = (state_q == S_START1);
    cmd_o.start2  = (state_q == S_START2);
    cmd_o.commit  = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_START1;
      S_START1: state_d = S_WAIT1;
      S_WAIT1:  if (stat_i.div_idle) state_d = S_START2;
      S_START2: state_d = S_WAIT2;
      S_WAIT2:  if (stat_i.div_idle) state_d = S_COMMIT;
      S_COMMIT: if (cmd_o.commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // result register is freed by the output transaction or refilled by a commit
  assign out_valid_d = cmd_o.commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `SSTS_ASSERT(a_ready_div_idle, clk_i, rst_ni, !in_ready_o || stat_i.div_idle, "ready while divider busy")
  `SSTS_ASSERT(a_pass2_after_pass1, clk_i, rst_ni, cmd_o.start2 |-> stat_i.div_idle, "owner pass started early")
  `SSTS_ASSERT(a_commit_shows, clk_i, rst_ni, cmd_o.commit |=> out_valid_o, "commit without result")

endmodule

`default_nettype wire

[hw/rtl/ssts_dp.sv]
// Datapath of the tick scheduler: config registers, scheduler state, dividers, result.
// Uses ssts_pkg and ssts_div.
`default_nettype none

module ssts_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssts_pkg::ssts_cmd_t             cmd_i,
  output ssts_pkg::ssts_stat_t            stat_o,
  input  logic                            cfg_we_i,
  input  logic [ssts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssts_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            hold_time_i,
  input  logic                            synced_i,
  input  logic                            logging_enabled_i,
  input  logic                            load_time_i,
  input  logic [ssts_pkg::TIME_W-1:0]     new_time_i,
  output logic                            advertise_o,
  output logic                            read_sensor_o,
  output logic                            window_boundary_o,
  output logic                            window_open_o,
  output logic [ssts_pkg::BYTE_W-1:0]     slot_owner_o,
  output logic [ssts_pkg::TIME_W-1:0]     time_now_o
);

  localparam int unsigned PAD_W = ssts_pkg::DIVR_W - ssts_pkg::BYTE_W;

  // configuration
  logic [15:0]                  window_period_q, sensing_interval_q;
  logic [ssts_pkg::BYTE_W-1:0]  slot_length_q, sensor_count_q, own_slot_q;
  logic [ssts_pkg::BYTE_W-1:0]  unsynced_period_q, sleep_length_q;

  // scheduler state
  logic [ssts_pkg::TIME_W-1:0]  gc_q, gc_d;
  logic                         win_q, sleeping_q, sa_q;
  logic [ssts_pkg::BYTE_W-1:0]  st_q, owner_q;
  logic [ssts_pkg::DIV_W-1:0]   timer_q;

  // tick inputs held for the divider passes
  logic synced_q, logging_q;

  // dividers
  logic                         busy0, busy1, busy2, busy3;
  logic [ssts_pkg::DIV_W-1:0]   quot0, quot1, quot2, quot3;
  logic [ssts_pkg::DIV_W-1:0]   rem0, rem1, rem2, rem3;
  logic [ssts_pkg::DIVR_W-1:0]  dvs0, dvs3;
  logic [ssts_pkg::DIV_W-1:0]   dvd3, q_end;
  logic                         start3;

  // commit decisions
  logic                         wb_c, wf_c, rd_c, end_c, sa_c, sleeping_c, own_upd, adv_c;
  logic [ssts_pkg::BYTE_W-1:0]  st1, st_c, owner_c;
  logic [ssts_pkg::DIV_W-1:0]   timer_c;

  // result register
  logic                         adv_q, rd_q, wb_q, wo_q;
  logic [ssts_pkg::BYTE_W-1:0]  so_q;
  logic [ssts_pkg::TIME_W-1:0]  tn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_period_q    <= ssts_pkg::WINDOW_PERIOD_RST;
      sensing_interval_q <= ssts_pkg::SENSING_INTERVAL_RST;
      slot_length_q      <= ssts_pkg::SLOT_LENGTH_RST;
      sensor_count_q     <= ssts_pkg::SENSOR_COUNT_RST;
      own_slot_q         <= ssts_pkg::OWN_SLOT_RST;
      unsynced_period_q  <= ssts_pkg::UNSYNCED_PERIOD_RST;
      sleep_length_q     <= ssts_pkg::SLEEP_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (ssts_pkg::cfg_idx_e'(cfg_idx_i))
        ssts_pkg::CFG_WINDOW_PERIOD:    window_period_q    <= cfg_data_i;
        ssts_pkg::CFG_SENSING_INTERVAL: sensing_interval_q <= cfg_data_i;
        ssts_pkg::CFG_SLOT_LENGTH:      slot_length_q      <= cfg_data_i[ssts_pkg::BYTE_W-1:0];
        ssts_pkg::CFG_SENSOR_COUNT:     sensor_count_q     <= cfg_data_i[ssts_pkg::BYTE_W-1:0];
        ssts_pkg::CFG_OWN_SLOT:         own_slot_q         <= cfg_data_i[ssts_pkg::BYTE_W-1:0];
        ssts_pkg::CFG_UNSYNCED_PERIOD:  unsynced_period_q  <= cfg_data_i[ssts_pkg::BYTE_W-1:0];
        ssts_pkg::CFG_SLEEP_LENGTH:     sleep_length_q     <= cfg_data_i[ssts_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // load first, then the increment unless held
  assign gc_d = (load_time_i ? new_time_i : gc_q)
              + {{(ssts_pkg::TIME_W-1){1'b0}}, ~hold_time_i};

  always_comb begin
    wb_c       = synced_q && (rem0 == '0);
    wf_c       = win_q || wb_c;
    rd_c       = synced_q && (rem1 == '0) && wf_c && logging_q;
    st1        = rd_c ? '0 : st_q;
    end_c      = synced_q && (st1 == sleep_length_q);
    sa_c       = end_c ? 1'b1 : (rd_c ? 1'b0 : sa_q);
    sleeping_c = end_c ? 1'b0 : (rd_c ? 1'b1 : sleeping_q);
    st_c       = end_c ? '0 : st1;
    timer_c    = end_c ? '0 : timer_q;
    own_upd    = synced_q && wf_c && sa_c;
    owner_c    = own_upd ? rem3[ssts_pkg::BYTE_W-1:0] : owner_q;
    adv_c      = synced_q ? (own_upd && (owner_c == own_slot_q) && (rem2 == '0) && logging_q)
                          : (rem0 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q       <= '0;
      win_q      <= 1'b0;
      sleeping_q <= 1'b0;
      st_q       <= '0;
      sa_q       <= 1'b0;
      timer_q    <= '0;
      owner_q    <= ssts_pkg::OWNER_NONE;
    end else if (cmd_i.capture) begin
      gc_q <= gc_d;
      if (sleeping_q) st_q <= st_q + 1'b1;
      if (sa_q) timer_q <= timer_q + 1'b1;
    end else if (cmd_i.commit) begin
      win_q      <= wf_c;
      sleeping_q <= sleeping_c;
      st_q       <= st_c;
      sa_q       <= sa_c;
      timer_q    <= timer_c;
      owner_q    <= owner_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      synced_q  <= synced_i;
      logging_q <= logging_enabled_i;
    end
    if (cmd_i.commit) begin
      adv_q <= adv_c;
      rd_q  <= rd_c;
      wb_q  <= wb_c;
      wo_q  <= wf_c;
      so_q  <= owner_c;
      tn_q  <= gc_q;
    end
  end

  // unit 0 tests window boundary after sync, advertise period before it
  assign dvs0 = synced_q ? window_period_q : {{PAD_W{1'b0}}, unsynced_period_q};

  // a slot timer restarted on this tick divides zero
  assign q_end  = (slot_length_q == '0) ? '1 : '0;
  assign start3 = cmd_i.start1 || cmd_i.start2;
  assign dvd3   = cmd_i.start2 ? (end_c ? q_end : quot3) : timer_q;
  assign dvs3   = cmd_i.start2 ? {{PAD_W{1'b0}}, sensor_count_q}
                               : {{PAD_W{1'b0}}, slot_length_q};

  ssts_div u_div_win (
    .clk_i, .rst_ni, .start_i(cmd_i.start1), .dividend_i(gc_q), .divisor_i(dvs0),
    .busy_o(busy0), .quot_o(quot0), .rem_o(rem0)
  );

  ssts_div u_div_sense (
    .clk_i, .rst_ni, .start_i(cmd_i.start1), .dividend_i(gc_q),
    .divisor_i(sensing_interval_q),
    .busy_o(busy1), .quot_o(quot1), .rem_o(rem1)
  );

  ssts_div u_div_slot (
    .clk_i, .rst_ni, .start_i(cmd_i.start1), .dividend_i(gc_q),
    .divisor_i({{PAD_W{1'b0}}, slot_length_q}),
    .busy_o(busy2), .quot_o(quot2), .rem_o(rem2)
  );

  ssts_div u_div_owner (
    .clk_i, .rst_ni, .start_i(start3), .dividend_i(dvd3), .divisor_i(dvs3),
    .busy_o(busy3), .quot_o(quot3), .rem_o(rem3)
  );

  // quotients of the remainder-only units are not needed
  logic unused_quot;
  assign unused_quot = ^{quot0, quot1, quot2};

  assign stat_o.div_idle = !(busy0 || busy1 || busy2 || busy3) || (unused_quot && 1'b0);

  assign advertise_o       = adv_q;
  assign read_sensor_o     = rd_q;
  assign window_boundary_o = wb_q;
  assign window_open_o     = wo_q;
  assign slot_owner_o      = so_q;
  assign time_now_o        = tn_q;

endmodule

`default_nettype wire

[hw/rtl/sensor_slot_tick_scheduler.sv]
// Each tick transaction runs two divider passes (start, busy cycles at 2 quotient bits
// each, idle check), then the commit that loads the result register.
// One tick in flight; the next tick is taken the cycle after commit.
// A result waiting in the output register stalls the following commit.
// Reset (async, active low) restores register defaults and clears state; owner_q = 255.
// Uses ssts_pkg, ssts_ctrl, ssts_dp, ssts_div.
`default_nettype none

module sensor_slot_tick_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssts_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            hold_time_i,
  input  logic                            synced_i,
  input  logic                            logging_enabled_i,
  input  logic                            load_time_i,
  input  logic [ssts_pkg::TIME_W-1:0]     new_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            advertise_o,
  output logic                            read_sensor_o,
  output logic                            window_boundary_o,
  output logic                            window_open_o,
  output logic [ssts_pkg::BYTE_W-1:0]     slot_owner_o,
  output logic [ssts_pkg::TIME_W-1:0]     time_now_o
);

  ssts_pkg::ssts_cmd_t  cmd;
  ssts_pkg::ssts_stat_t stat;

  ssts_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  ssts_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .hold_time_i,
    .synced_i,
    .logging_enabled_i,
    .load_time_i,
    .new_time_i,
    .advertise_o,
    .read_sensor_o,
    .window_boundary_o,
    .window_open_o,
    .slot_owner_o,
    .time_now_o
  );

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for sensor_slot_tick_scheduler: random and directed tick stimulus with a
// predicting scoreboard class; depends on ssts_pkg and the block's RTL only.

module tb_top;
  import ssts_pkg::*;

  localparam int unsigned LIMIT_NS        = 2_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TICKS_PER_PHASE = 56;

  typedef enum int { SET_DEEP, SET_MAX, SET_MIN, SET_ANY } setting_kind_e;

  typedef struct packed {
    logic        adv;
    logic        rd;
    logic        wb;
    logic        wopen;
    logic [7:0]  owner;
    logic [31:0] now;
  } tick_result_t;

  // Predicts one result per tick and checks results in order.
  class tick_scoreboard;
    logic [15:0] window_period, sensing_interval;
    logic [7:0]  slot_length, sensor_count, own_slot, unsynced_period, sleep_length;
    logic [31:0] gtime, slot_cnt;
    logic [7:0]  sleep_cnt, owner;
    logic        win_flag, sleeping, slots_on;
    tick_result_t expected_q[$];
    int errors, checked, noted;

    function new();
      window_period    = WINDOW_PERIOD_RST;
      sensing_interval = SENSING_INTERVAL_RST;
      slot_length      = SLOT_LENGTH_RST;
      sensor_count     = SENSOR_COUNT_RST;
      own_slot         = OWN_SLOT_RST;
      unsynced_period  = UNSYNCED_PERIOD_RST;
      sleep_length     = SLEEP_LENGTH_RST;
      gtime    = '0;
      slot_cnt = '0;
      sleep_cnt = '0;
      owner    = OWNER_NONE;
      win_flag = 1'b0;
      sleeping = 1'b0;
      slots_on = 1'b0;
      errors = 0;
      checked = 0;
      noted = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_WINDOW_PERIOD:    window_period    = val;
        CFG_SENSING_INTERVAL: sensing_interval = val;
        CFG_SLOT_LENGTH:      slot_length      = val[7:0];
        CFG_SENSOR_COUNT:     sensor_count     = val[7:0];
        CFG_OWN_SLOT:         own_slot         = val[7:0];
        CFG_UNSYNCED_PERIOD:  unsynced_period  = val[7:0];
        CFG_SLEEP_LENGTH:     sleep_length     = val[7:0];
        default: ;
      endcase
    endfunction

    // zero divisor: remainder is the dividend, quotient all ones
    function logic [31:0] rem_or_self(logic [31:0] x, logic [31:0] d);
      return (d == 0) ? x : x % d;
    endfunction

    function logic [31:0] quo_or_ones(logic [31:0] x, logic [31:0] d);
      return (d == 0) ? 32'hFFFF_FFFF : x / d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_tick(logic hold_v, logic sync_v, logic log_v, logic load_v,
                            logic [31:0] nt_v);
      tick_result_t r;
      logic [31:0] q, m;
      r = '0;
      if (load_v) gtime = nt_v;
      if (!hold_v) gtime = gtime + 32'd1;
      if (sleeping) sleep_cnt = sleep_cnt + 8'd1;
      if (slots_on) slot_cnt = slot_cnt + 32'd1;
      if (!sync_v) begin
        if (rem_or_self(gtime, {24'd0, unsynced_period}) == 0) r.adv = 1'b1;
      end else begin
        if (rem_or_self(gtime, {16'd0, window_period}) == 0) begin
          win_flag = 1'b1;
          r.wb = 1'b1;
        end
        if (rem_or_self(gtime, {16'd0, sensing_interval}) == 0 && win_flag && log_v) begin
          r.rd = 1'b1;
          sleeping = 1'b1;
          sleep_cnt = '0;
          slots_on = 1'b0;
        end
        // compared even when not sleeping
        if (sleep_cnt == sleep_length) begin
          sleep_cnt = '0;
          sleeping = 1'b0;
          slot_cnt = '0;
          slots_on = 1'b1;
        end
        if (win_flag && slots_on) begin
          q = quo_or_ones(slot_cnt, {24'd0, slot_length});
          m = rem_or_self(q, {24'd0, sensor_count});
          owner = m[7:0];
          if (owner == own_slot && log_v &&
              rem_or_self(gtime, {24'd0, slot_length}) == 0) r.adv = 1'b1;
        end
      end
      r.wopen = win_flag;
      r.owner = owner;
      r.now = gtime;
      expected_q.push_back(r);
      noted++;
    endfunction

    task report(string field, logic [31:0] got_v, logic [31:0] exp_v);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
               $time, field, got_v, exp_v, checked);
      errors++;
    endtask

    task check_result(tick_result_t got);
      tick_result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", got.now, '0);
        return;
      end
      e = expected_q.pop_front();
      if (got.adv !== e.adv)     report("advertise", got.adv, e.adv);
      if (got.rd !== e.rd)       report("read_sensor", got.rd, e.rd);
      if (got.wb !== e.wb)       report("window_boundary", got.wb, e.wb);
      if (got.wopen !== e.wopen) report("window_open", got.wopen, e.wopen);
      if (got.owner !== e.owner) report("slot_owner", got.owner, e.owner);
      if (got.now !== e.now)     report("time_now", got.now, e.now);
      checked++;
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i         = '0;
  logic [CFG_W-1:0]     cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic                 hold_time_i       = 1'b0;
  logic                 synced_i          = 1'b0;
  logic                 logging_enabled_i = 1'b0;
  logic                 load_time_i       = 1'b0;
  logic [TIME_W-1:0]    new_time_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i       = 1'b0;
  logic                 advertise_o;
  logic                 read_sensor_o;
  logic                 window_boundary_o;
  logic                 window_open_o;
  logic [BYTE_W-1:0]    slot_owner_o;
  logic [TIME_W-1:0]    time_now_o;

  tick_scoreboard sb;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int settings_cnt = 0;

  sensor_slot_tick_scheduler dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // transaction monitor on both channels
  always @(posedge clk_i) begin : mon
    tick_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_tick(hold_time_i, synced_i, logging_enabled_i, load_time_i, new_time_i);
      if (out_valid_o && out_ready_i) begin
        got.adv   = advertise_o;
        got.rd    = read_sensor_o;
        got.wb    = window_boundary_o;
        got.wopen = window_open_o;
        got.owner = slot_owner_o;
        got.now   = time_now_o;
        sb.check_result(got);
      end
    end
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_cfg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] wp, logic [15:0] si, logic [7:0] sl,
                           logic [7:0] sc, logic [7:0] own, logic [7:0] up,
                           logic [7:0] slp);
    write_reg(CFG_WINDOW_PERIOD, wp);
    write_reg(CFG_SENSING_INTERVAL, si);
    write_reg(CFG_SLOT_LENGTH, {8'd0, sl});
    write_reg(CFG_SENSOR_COUNT, {8'd0, sc});
    write_reg(CFG_OWN_SLOT, {8'd0, own});
    write_reg(CFG_UNSYNCED_PERIOD, {8'd0, up});
    write_reg(CFG_SLEEP_LENGTH, {8'd0, slp});
    settings_cnt++;
  endtask

  task automatic apply_setting(setting_kind_e kind);
    logic [7:0] sc;
    case (kind)
      SET_DEEP: begin
        sc = 8'($urandom_range(1, 5));
        write_all(16'($urandom_range(2, 12)), 16'($urandom_range(2, 16)),
                  8'($urandom_range(1, 4)), sc, 8'($urandom_range(0, sc)),
                  8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)));
      end
      SET_MAX: write_all(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      SET_MIN: write_all(16'd1, 16'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1);
      default: write_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                         8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(1, 255)));
    endcase
  endtask

  // one tick transaction; valid is held until accepted
  task automatic send_tick(logic hold_v, logic sync_v, logic log_v, logic load_v,
                           logic [31:0] nt_v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    hold_time_i       <= hold_v;
    synced_i          <= sync_v;
    logging_enabled_i <= log_v;
    load_time_i       <= load_v;
    new_time_i        <= nt_v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // load values: random, near wrap, or at or just before a window or sensing boundary
  function automatic logic [31:0] pick_time();
    logic [31:0] per;
    per = $urandom_range(0, 1) ? {16'd0, sb.window_period} : {16'd0, sb.sensing_interval};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default: return 32'($urandom_range(0, 32'hFFFF)) * per - 32'($urandom_range(0, 2));
    endcase
  endfunction

  task automatic send_random();
    if ($urandom_range(0, 4) != 0)
      send_tick($urandom_range(0, 9) == 0, $urandom_range(0, 19) != 0,
                $urandom_range(0, 9) != 0, $urandom_range(0, 24) == 0, pick_time());
    else
      send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    setting_kind_e plan[8];
    sb = new();
    plan = '{SET_DEEP, SET_DEEP, SET_MAX, SET_MIN, SET_DEEP, SET_ANY, SET_DEEP, SET_DEEP};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default registers, unsynced advertise, load/hold, time wrap
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 32'd14);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0, 32'd0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1, 32'd59);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 32'hAAAA_5555);
    drain();

    // directed: short periods so a read, the sleep and the slot walk all happen
    write_all(16'd4, 16'd8, 8'd2, 8'd2, 8'd0, 8'd3, 8'd2);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1, 32'd7);
    repeat (6) send_tick(1'b0, 1'b1, 1'b1, 1'b0, 32'd0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 32'd0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
    repeat (3) send_tick(1'b0, 1'b1, 1'b1, 1'b0, 32'd0);
    drain();

    // directed: every divisor register at zero
    write_all(16'd0, 16'd0, 8'd0, 8'd0, 8'hFF, 8'd0, 8'd0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 32'd0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 32'd0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    drain();

    foreach (plan[p]) begin
      apply_setting(plan[p]);
      calm = (p == 7);
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        if (p == 1 && i == 10) hold_off_req = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (60) @(posedge clk_i);
    $display("Sent %0d ticks under %0d register settings (zero divisors and full range).",
             sb.noted, settings_cnt);
    $display("Compared %0d results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
